### rtl/core/rfca_pkg.sv
// shared types, constants and the crc-16 byte step for the radio frame checker
// no dependencies
package rfca_pkg;

    localparam int MAX_FRAME_BYTES = 64;
    localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int MIN_FRAME_BYTES = 8;
    localparam int ACK_BYTES       = 8;
    localparam int IDX_W           = $clog2(ACK_BYTES + 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    localparam logic [7:0] RST_MAGIC    = 8'hA5;
    localparam logic [7:0] RST_VERSION  = 8'h01;
    localparam logic [7:0] RST_DATA     = 8'h10;
    localparam logic [7:0] RST_ACK_TYPE = 8'h20;
    localparam logic [7:0] RST_GATEWAY  = 8'hF0;
    localparam logic [7:0] RST_PLEN     = 8'd16;
    localparam logic [7:0] RST_LAST_SEQ = 8'd255;
    localparam logic [7:0] ACK_PAD      = 8'h00;

    typedef enum logic [2:0] {
        CFG_MAGIC    = 3'd0,
        CFG_VERSION  = 3'd1,
        CFG_DATA     = 3'd2,
        CFG_ACK_TYPE = 3'd3,
        CFG_GATEWAY  = 3'd4,
        CFG_PLEN     = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_NEW   = 3'd0,
        ST_DUP   = 3'd1,
        ST_SHORT = 3'd2,
        ST_LONG  = 3'd3,
        ST_BAD   = 3'd4,
        ST_PLEN  = 3'd5
    } t_status;

    // ack item positions in the output run
    localparam logic [IDX_W-1:0] IT_VERDICT  = IDX_W'(0);
    localparam logic [IDX_W-1:0] IT_MAGIC    = IDX_W'(1);
    localparam logic [IDX_W-1:0] IT_VERSION  = IDX_W'(2);
    localparam logic [IDX_W-1:0] IT_ACK_TYPE = IDX_W'(3);
    localparam logic [IDX_W-1:0] IT_GATEWAY  = IDX_W'(4);
    localparam logic [IDX_W-1:0] IT_SEQ      = IDX_W'(5);
    localparam logic [IDX_W-1:0] IT_PAD      = IDX_W'(6);
    localparam logic [IDX_W-1:0] IT_CRC_HI   = IDX_W'(7);
    localparam logic [IDX_W-1:0] IT_CRC_LO   = IDX_W'(8);

    typedef struct packed {
        t_status    status;
        logic [7:0] node;
        logic [7:0] seq;
    } t_verdict;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_MSB) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### rtl/core/radio_frame_check_and_ack_top.sv
// Takes one frame byte per cycle; the last byte of a frame (tlast) yields one verdict beat,
// followed by eight ack beats when the frame is new or a duplicate. The verdict is decided in
// the cycle its last byte is accepted, and its beat is offered from the next cycle on when the
// emitter is free. The byte path sustains one byte per cycle; the output side gives 1 or 9 beats
// per frame at one beat per ready cycle. A frame that ends while the emitter is busy parks its
// verdict in a holding slot, and while that slot is full tready stays low for every byte, until
// the emitter takes the held verdict. Ack crc bytes are built one byte per beat in the emitter.
// depends on rfca_pkg
module radio_frame_check_and_ack_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // byte_value
    input  logic        s_axis_tlast,   // end_of_frame
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // status[2:0], node_id[10:3], sequence_res[18:11],
                                        // ack_byte[26:19], zero fill
    output logic        m_axis_tuser,   // kind
    output logic        m_axis_tlast    // last
);
    import rfca_pkg::*;

    // configuration
    logic [7:0] r_magic, r_version, r_data_type, r_ack_type, r_gateway, r_plen;

    // frame state
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_too_long, n_too_long;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_tail0, r_tail1;
    logic             r_hdr_ok, n_hdr_ok;
    logic [7:0]       r_node, n_node, r_seq, n_seq, r_plen_cap, n_plen_cap;
    logic [7:0]       r_last_seq;

    // emitter and holding slot
    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    t_verdict         r_cur;
    logic [15:0]      r_ack_crc;
    logic             r_pend_valid;
    t_verdict         r_pend;

    logic     in_fire, v_fire, out_fire, emit_free, out_last;
    t_verdict new_v;
    logic [7:0] ack_byte;
    logic       accepted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic     <= RST_MAGIC;
            r_version   <= RST_VERSION;
            r_data_type <= RST_DATA;
            r_ack_type  <= RST_ACK_TYPE;
            r_gateway   <= RST_GATEWAY;
            r_plen      <= RST_PLEN;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_MAGIC:    r_magic     <= i_cfg_data;
                CFG_VERSION:  r_version   <= i_cfg_data;
                CFG_DATA:     r_data_type <= i_cfg_data;
                CFG_ACK_TYPE: r_ack_type  <= i_cfg_data;
                CFG_GATEWAY:  r_gateway   <= i_cfg_data;
                CFG_PLEN:     r_plen      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !r_pend_valid;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign v_fire        = in_fire && s_axis_tlast;

    // per-byte update
    always_comb begin
        n_crc      = (r_cnt >= CNT_W'(2)) ? crc_byte(r_crc, r_tail0) : r_crc;
        n_hdr_ok   = r_hdr_ok;
        n_node     = r_node;
        n_seq      = r_seq;
        n_plen_cap = r_plen_cap;
        if (r_cnt == CNT_W'(0) && s_axis_tdata != r_magic)     n_hdr_ok = 1'b0;
        if (r_cnt == CNT_W'(1) && s_axis_tdata != r_version)   n_hdr_ok = 1'b0;
        if (r_cnt == CNT_W'(2) && s_axis_tdata != r_data_type) n_hdr_ok = 1'b0;
        if (r_cnt == CNT_W'(3)) n_node     = s_axis_tdata;
        if (r_cnt == CNT_W'(4)) n_seq      = s_axis_tdata;
        if (r_cnt == CNT_W'(5)) n_plen_cap = s_axis_tdata;
        if (r_cnt < CNT_W'(MAX_FRAME_BYTES)) begin
            n_cnt      = r_cnt + CNT_W'(1);
            n_too_long = r_too_long;
        end else begin
            n_cnt      = r_cnt;
            n_too_long = 1'b1;
        end

        new_v.node = n_node;
        new_v.seq  = n_seq;
        if (n_cnt < CNT_W'(MIN_FRAME_BYTES)) begin
            new_v.status = ST_SHORT;
        end else if (n_too_long) begin
            new_v.status = ST_LONG;
        end else if ({r_tail1, s_axis_tdata} != n_crc || !n_hdr_ok) begin
            new_v.status = ST_BAD;
        end else if (n_plen_cap != r_plen) begin
            new_v.status = ST_PLEN;
        end else if (n_seq == r_last_seq) begin
            new_v.status = ST_DUP;
        end else begin
            new_v.status = ST_NEW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || v_fire) begin
            r_cnt      <= '0;
            r_too_long <= 1'b0;
            r_crc      <= CRC_INIT;
            r_tail0    <= 8'h00;
            r_tail1    <= 8'h00;
            r_hdr_ok   <= 1'b1;
            r_node     <= 8'h00;
            r_seq      <= 8'h00;
            r_plen_cap <= 8'h00;
        end else if (in_fire) begin
            r_cnt      <= n_cnt;
            r_too_long <= n_too_long;
            r_crc      <= n_crc;
            r_tail0    <= r_tail1;
            r_tail1    <= s_axis_tdata;
            r_hdr_ok   <= n_hdr_ok;
            r_node     <= n_node;
            r_seq      <= n_seq;
            r_plen_cap <= n_plen_cap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_seq <= RST_LAST_SEQ;
        end else if (v_fire && new_v.status == ST_NEW) begin
            r_last_seq <= new_v.seq;
        end
    end

    // output side
    assign accepted = (r_cur.status == ST_NEW) || (r_cur.status == ST_DUP);
    assign out_last = (r_idx == IT_CRC_LO) || (r_idx == IT_VERDICT && !accepted);
    assign out_fire = r_busy && m_axis_tready;
    assign emit_free = !r_busy || (out_fire && out_last);

    always_comb begin
        case (r_idx)
            IT_MAGIC:    ack_byte = r_magic;
            IT_VERSION:  ack_byte = r_version;
            IT_ACK_TYPE: ack_byte = r_ack_type;
            IT_GATEWAY:  ack_byte = r_gateway;
            IT_SEQ:      ack_byte = r_cur.seq;
            IT_PAD:      ack_byte = ACK_PAD;
            IT_CRC_HI:   ack_byte = r_ack_crc[15:8];
            IT_CRC_LO:   ack_byte = r_ack_crc[7:0];
            default:     ack_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_idx        <= IT_VERDICT;
        end else begin
            if (emit_free) begin
                r_idx <= IT_VERDICT;
                if (r_pend_valid) begin
                    r_busy       <= 1'b1;
                    r_pend_valid <= 1'b0;
                end else begin
                    r_busy <= v_fire;
                end
            end else begin
                if (out_fire) r_idx <= r_idx + IDX_W'(1);
                if (v_fire)   r_pend_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_free) begin
            r_cur     <= r_pend_valid ? r_pend : new_v;
            r_ack_crc <= CRC_INIT;
        end else if (out_fire && r_idx >= IT_MAGIC && r_idx <= IT_PAD) begin
            r_ack_crc <= crc_byte(r_ack_crc, ack_byte);
        end
        if (v_fire && !(emit_free && !r_pend_valid)) begin
            r_pend <= new_v;
        end
    end

    assign m_axis_tvalid = r_busy;
    assign m_axis_tuser  = (r_idx != IT_VERDICT);
    assign m_axis_tlast  = out_last;
    assign m_axis_tdata  = {5'b00000, ack_byte, r_cur.seq, r_cur.node, r_cur.status};

`ifndef SYNTHESIS
    a_pend_needs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_busy)
        else $error("holding slot full while emitter idle");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= IT_CRC_LO))
        else $error("emitter index out of range");

    a_accept_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_idx == IT_VERDICT && (r_cur.status == ST_NEW || r_cur.status == ST_DUP))
        |-> !m_axis_tlast)
        else $error("accepted verdict marked last");

    a_drain_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && out_last && !r_pend_valid && !v_fire) |=> !r_busy)
        else $error("emitter stays busy after final beat");
`endif

endmodule

### verif/rfca_frame_checker.sv
// frame checker for radio_frame_check_and_ack_top: rebuilds verdict and ack beats from
// accepted input bytes and register writes, and compares them with the output channel
// depends on rfca_pkg; also holds tb_ccitt_pkg, shared with the testbench top
`timescale 1ns / 1ps

package tb_ccitt_pkg;
    import rfca_pkg::CRC_POLY;

    // crc-16 ccitt, msb first, one data bit per shift
    function automatic logic [15:0] ccitt_update(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int k = 7; k >= 0; k--) begin
            fb = r[15] ^ b[k];
            r  = {r[14:0], 1'b0};
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction
endpackage

module rfca_frame_checker
    import rfca_pkg::*;
    import tb_ccitt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_s_valid,
    input  logic        i_s_ready,
    input  logic [7:0]  i_s_data,
    input  logic        i_s_last,
    input  logic        i_m_valid,
    input  logic        i_m_ready,
    input  logic [31:0] i_m_data,
    input  logic        i_m_user,
    input  logic        i_m_last,
    output int          o_err_count,
    output int          o_pending,
    output int          o_beats_checked
);

    typedef struct {
        logic       kind;
        t_status    status;
        logic [7:0] node;
        logic [7:0] seq;
        logic [7:0] ack;
        logic       last;
    } t_reply_beat;

    t_reply_beat frame_reply_q[$];

    logic [7:0]  reg_magic, reg_version, reg_data, reg_ack_type, reg_gateway, reg_plen;
    int          fr_count;
    logic        fr_overrun;
    logic [15:0] fr_crc;
    logic [7:0]  fr_tail [2];
    logic        fr_hdr_ok;
    logic [7:0]  fr_node, fr_seq, fr_plen;
    logic [7:0]  acc_seq;
    int          errs  = 0;
    int          beats = 0;

    function automatic void clear_frame();
        fr_count   = 0;
        fr_overrun = 1'b0;
        fr_crc     = CRC_INIT;
        fr_tail[0] = 8'h00;
        fr_tail[1] = 8'h00;
        fr_hdr_ok  = 1'b1;
        fr_node    = 8'h00;
        fr_seq     = 8'h00;
        fr_plen    = 8'h00;
    endfunction

    function automatic void queue_reply(logic kind, t_status st, logic [7:0] ack, logic last);
        t_reply_beat r;
        r.kind   = kind;
        r.status = st;
        r.node   = fr_node;
        r.seq    = fr_seq;
        r.ack    = ack;
        r.last   = last;
        frame_reply_q.push_back(r);
    endfunction

    task automatic absorb_byte(input logic [7:0] b, input logic eof);
        int          pos;
        t_status     st;
        logic [15:0] rx_crc;
        logic [15:0] ack_crc;
        logic [7:0]  ack [ACK_BYTES];
        pos = fr_count;
        // crc trails the input by two bytes so the received crc stays out of it
        if (pos >= 2) begin
            fr_crc = ccitt_update(fr_crc, fr_tail[0]);
        end
        fr_tail[0] = fr_tail[1];
        fr_tail[1] = b;
        if (pos == 0 && b != reg_magic)   fr_hdr_ok = 1'b0;
        if (pos == 1 && b != reg_version) fr_hdr_ok = 1'b0;
        if (pos == 2 && b != reg_data)    fr_hdr_ok = 1'b0;
        if (pos == 3) fr_node = b;
        if (pos == 4) fr_seq  = b;
        if (pos == 5) fr_plen = b;
        if (fr_count < MAX_FRAME_BYTES) begin
            fr_count++;
        end else begin
            fr_overrun = 1'b1;
        end
        if (!eof) begin
            return;
        end
        rx_crc = {fr_tail[0], fr_tail[1]};
        if (fr_count < MIN_FRAME_BYTES)             st = ST_SHORT;
        else if (fr_overrun)                        st = ST_LONG;
        else if (rx_crc != fr_crc || !fr_hdr_ok)    st = ST_BAD;
        else if (fr_plen != reg_plen)               st = ST_PLEN;
        else if (fr_seq == acc_seq)                 st = ST_DUP;
        else                                        st = ST_NEW;
        if (st != ST_NEW && st != ST_DUP) begin
            queue_reply(1'b0, st, 8'h00, 1'b1);
        end else begin
            if (st == ST_NEW) begin
                acc_seq = fr_seq;
            end
            ack[0] = reg_magic;
            ack[1] = reg_version;
            ack[2] = reg_ack_type;
            ack[3] = reg_gateway;
            ack[4] = fr_seq;
            ack[5] = ACK_PAD;
            ack_crc = CRC_INIT;
            for (int i = 0; i < 6; i++) begin
                ack_crc = ccitt_update(ack_crc, ack[i]);
            end
            ack[6] = ack_crc[15:8];
            ack[7] = ack_crc[7:0];
            queue_reply(1'b0, st, 8'h00, 1'b0);
            for (int i = 0; i < ACK_BYTES; i++) begin
                queue_reply(1'b1, st, ack[i], i == ACK_BYTES - 1);
            end
        end
        clear_frame();
    endtask

    function automatic int field_diff(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_reply_beat w;
        if (!i_rst_n) begin
            reg_magic    = RST_MAGIC;
            reg_version  = RST_VERSION;
            reg_data     = RST_DATA;
            reg_ack_type = RST_ACK_TYPE;
            reg_gateway  = RST_GATEWAY;
            reg_plen     = RST_PLEN;
            acc_seq      = RST_LAST_SEQ;
            clear_frame();
            frame_reply_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_MAGIC:    reg_magic    = i_cfg_data;
                    CFG_VERSION:  reg_version  = i_cfg_data;
                    CFG_DATA:     reg_data     = i_cfg_data;
                    CFG_ACK_TYPE: reg_ack_type = i_cfg_data;
                    CFG_GATEWAY:  reg_gateway  = i_cfg_data;
                    CFG_PLEN:     reg_plen     = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_valid && i_s_ready) begin
                absorb_byte(i_s_data, i_s_last);
            end
            if (i_m_valid && i_m_ready) begin
                if (frame_reply_q.size() == 0) begin
                    $error("output beat with nothing pending: tdata %h, tuser %b, tlast %b",
                           i_m_data, i_m_user, i_m_last);
                    errs++;
                end else begin
                    w = frame_reply_q.pop_front();
                    errs += field_diff("kind", {7'h00, w.kind}, {7'h00, i_m_user});
                    errs += field_diff("status", {5'h00, w.status}, {5'h00, i_m_data[2:0]});
                    errs += field_diff("node_id",      w.node,   i_m_data[10:3]);
                    errs += field_diff("sequence_res", w.seq,    i_m_data[18:11]);
                    errs += field_diff("ack_byte",     w.ack,    i_m_data[26:19]);
                    errs += field_diff("last", {7'h00, w.last}, {7'h00, i_m_last});
                    beats++;
                end
            end
        end
        o_pending       <= frame_reply_q.size();
        o_err_count     <= errs;
        o_beats_checked <= beats;
    end

endmodule

### verif/tb_radio_frame_check_and_ack_top.sv
// testbench top for radio_frame_check_and_ack_top: drives frames and register settings,
// idles both stream sides, and reports the result counted by rfca_frame_checker
// depends on rfca_pkg, tb_ccitt_pkg and rfca_frame_checker
`timescale 1ns / 1ps

module tb_radio_frame_check_and_ack_top;
    import rfca_pkg::*;
    import tb_ccitt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SQUEEZE_CYCLES = 400;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [2:0]  i_cfg_idx;
    logic [7:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // byte_value
    logic        s_axis_tlast;   // end_of_frame
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // status, node_id, sequence_res, ack_byte, zero fill
    logic        m_axis_tuser;   // kind
    logic        m_axis_tlast;   // last

    int err_count, pending, beats_checked;
    int cyc_count    = 0;
    int bytes_sent   = 0;
    int frames_sent  = 0;
    int burst_left   = 0;
    bit squeeze_req  = 0;

    logic [7:0] sh_magic   = RST_MAGIC;
    logic [7:0] sh_version = RST_VERSION;
    logic [7:0] sh_data    = RST_DATA;
    logic [7:0] sh_plen    = RST_PLEN;
    logic [7:0] prev_seq   = RST_LAST_SEQ;
    logic [7:0] frame_bytes[$];

    radio_frame_check_and_ack_top dut (.*);

    rfca_frame_checker chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_valid       (s_axis_tvalid),
        .i_s_ready       (s_axis_tready),
        .i_s_data        (s_axis_tdata),
        .i_s_last        (s_axis_tlast),
        .i_m_valid       (m_axis_tvalid),
        .i_m_ready       (m_axis_tready),
        .i_m_data        (m_axis_tdata),
        .i_m_user        (m_axis_tuser),
        .i_m_last        (m_axis_tlast),
        .o_err_count     (err_count),
        .o_pending       (pending),
        .o_beats_checked (beats_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cyc_count <= cyc_count + 1;

    initial begin
        wait (cyc_count >= CYCLE_LIMIT);
        $display("tb_radio_frame_check_and_ack_top: done, errors");
        $finish;
    end

    // receiver: segments of steady, random, mostly stalled or toggling ready
    initial begin
        int  seg_len;
        int  mode;
        bit  phase_bit;
        m_axis_tready <= 1'b0;
        phase_bit = 1'b0;
        forever begin
            seg_len = $urandom_range(4, 60);
            mode    = $urandom_range(0, 3);
            for (int i = 0; i < seg_len; i++) begin
                if (squeeze_req) begin
                    squeeze_req = 0;
                    m_axis_tready <= 1'b0;
                    repeat (SQUEEZE_CYCLES) @(posedge i_clk);
                end else begin
                    phase_bit = ~phase_bit;
                    case (mode)
                        0:       m_axis_tready <= 1'b1;
                        1:       m_axis_tready <= 1'($urandom_range(0, 1));
                        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                        default: m_axis_tready <= phase_bit;
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic eof);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eof;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i]) begin
            push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        end
        frames_sent++;
    endtask

    function automatic void start_frame(logic [7:0] node, logic [7:0] seq, logic [7:0] plen,
                                        int npay);
        frame_bytes = '{sh_magic, sh_version, sh_data, node, seq, plen};
        repeat (npay) frame_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void seal_frame();
        logic [15:0] c;
        c = CRC_INIT;
        foreach (frame_bytes[i]) c = ccitt_update(c, frame_bytes[i]);
        frame_bytes.push_back(c[15:8]);
        frame_bytes.push_back(c[7:0]);
    endfunction

    task automatic send_good(input logic [7:0] seq, input int npay);
        start_frame(8'($urandom_range(0, 255)), seq, sh_plen, npay);
        seal_frame();
        send_frame();
    endtask

    task automatic random_frame();
        int         pick;
        int         idx;
        logic [7:0] seq;
        pick = $urandom_range(0, 99);
        seq  = ($urandom_range(0, 3) == 0) ? prev_seq : 8'($urandom_range(0, 255));
        start_frame(8'($urandom_range(0, 255)), seq, sh_plen, $urandom_range(0, 6));
        if (pick < 70) begin
            prev_seq = seq;
            seal_frame();
        end else if (pick < 78) begin
            idx = $urandom_range(0, 2);
            frame_bytes[idx] = frame_bytes[idx] ^ 8'($urandom_range(1, 255));
            seal_frame();
        end else if (pick < 84) begin
            seal_frame();
            idx = $urandom_range(0, frame_bytes.size() - 1);
            frame_bytes[idx] = frame_bytes[idx] ^ 8'($urandom_range(1, 255));
        end else if (pick < 89) begin
            frame_bytes[5] = frame_bytes[5] ^ 8'($urandom_range(1, 255));
            seal_frame();
        end else if (pick < 94) begin
            seal_frame();
            frame_bytes = frame_bytes[0:$urandom_range(0, MIN_FRAME_BYTES - 2)];
        end else begin
            frame_bytes = {};
            repeat ($urandom_range(MIN_FRAME_BYTES, 14))
                frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
        send_frame();
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= v;
        case (idx)
            CFG_MAGIC:   sh_magic   = v;
            CFG_VERSION: sh_version = v;
            CFG_DATA:    sh_data    = v;
            CFG_PLEN:    sh_plen    = v;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [7:0] m, input logic [7:0] v, input logic [7:0] d,
                                  input logic [7:0] a, input logic [7:0] g,
                                  input logic [7:0] p);
        write_reg(CFG_MAGIC, m);
        write_reg(CFG_VERSION, v);
        write_reg(CFG_DATA, d);
        write_reg(CFG_ACK_TYPE, a);
        write_reg(CFG_GATEWAY, g);
        write_reg(CFG_PLEN, p);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait until every predicted beat is out, then let the output side settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    task automatic random_run(input int byte_goal);
        while (bytes_sent < byte_goal) random_frame();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_idx     <= CFG_MAGIC;
        i_cfg_data    <= 8'h00;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tlast  <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single byte frame, short frame with node and sequence, longest short frame
        frame_bytes = '{sh_magic};
        send_frame();
        start_frame(8'h5A, 8'h3C, sh_plen, 0);
        frame_bytes = frame_bytes[0:4];
        send_frame();
        start_frame(8'h11, 8'h22, sh_plen, 0);
        frame_bytes = frame_bytes[0:MIN_FRAME_BYTES - 2];
        send_frame();
        // sequence equal to the one after reset is a duplicate, then new, then duplicate
        send_good(RST_LAST_SEQ, 0);
        send_good(8'h00, 0);
        send_good(8'h00, 0);
        // bad crc, bad magic with valid crc, bad payload length
        start_frame(8'hFF, 8'h01, sh_plen, 0);
        seal_frame();
        frame_bytes[MIN_FRAME_BYTES - 1] = frame_bytes[MIN_FRAME_BYTES - 1] ^ 8'h01;
        send_frame();
        start_frame(8'h00, 8'h02, sh_plen, 0);
        frame_bytes[0] = ~frame_bytes[0];
        seal_frame();
        send_frame();
        start_frame(8'h80, 8'h03, ~sh_plen, 0);
        seal_frame();
        send_frame();
        prev_seq = 8'h00;
        drain();

        apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        // largest legal frame, then one that runs one to four bytes past the limit
        send_good(8'h40, MAX_FRAME_BYTES - MIN_FRAME_BYTES);
        send_good(8'h41, MAX_FRAME_BYTES - MIN_FRAME_BYTES + $urandom_range(1, 4));
        // output stalls long while minimum-length good frames keep coming
        squeeze_req = 1;
        for (int i = 0; i < 10; i++) send_good(8'($urandom_range(0, 255)), 0);
        random_run(300);
        drain();

        apply_settings(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        random_run(370);
        drain();

        apply_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        random_run(440);
        drain();

        $display("run: %0d bytes in %0d frames, %0d output beats checked", bytes_sent,
                 frames_sent, beats_checked);
        $display("run: reset, random, all-zero and all-one settings, one long output stall");
        if (err_count == 0) begin
            $display("tb_radio_frame_check_and_ack_top: done, clean");
        end else begin
            $display("tb_radio_frame_check_and_ack_top: done, errors");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/rfca_pkg.sv
rtl/core/radio_frame_check_and_ack_top.sv
verif/rfca_frame_checker.sv
verif/tb_radio_frame_check_and_ack_top.sv
